// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk with rst_n low disabling the check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SPN_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SPN_ASSERT(lbl, prop, msg)

`define SPN_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== hdl/spn_pkg.sv =====
package spn_pkg;

  localparam int unsigned BlkW   = 16;
  localparam int unsigned KeyCnt = 7;
  localparam int unsigned MaxRnd = 6;

  typedef logic [BlkW-1:0] blk_t;

  // operation codes carried with each item
  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  // control that travels with the data through each stage
  typedef struct packed {
    logic valid;
    op_t  op;
  } spn_ctl_t;

  // forward substitution box
  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hF;
      4'h1: y = 4'h6;
      4'h2: y = 4'h5;
      4'h3: y = 4'h8;
      4'h4: y = 4'hE;
      4'h5: y = 4'hB;
      4'h6: y = 4'hA;
      4'h7: y = 4'h4;
      4'h8: y = 4'hC;
      4'h9: y = 4'h0;
      4'hA: y = 4'h3;
      4'hB: y = 4'h7;
      4'hC: y = 4'h2;
      4'hD: y = 4'h9;
      4'hE: y = 4'h1;
      4'hF: y = 4'hD;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // inverse substitution box
  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h9;
      4'h1: y = 4'hE;
      4'h2: y = 4'hC;
      4'h3: y = 4'hA;
      4'h4: y = 4'h7;
      4'h5: y = 4'h2;
      4'h6: y = 4'h1;
      4'h7: y = 4'hB;
      4'h8: y = 4'h3;
      4'h9: y = 4'hD;
      4'hA: y = 4'h6;
      4'hB: y = 4'h5;
      4'hC: y = 4'h8;
      4'hD: y = 4'hF;
      4'hE: y = 4'h4;
      4'hF: y = 4'h0;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // per-nibble substitution, forward or inverse
  function automatic blk_t sub_blk(input blk_t v, input logic inv);
    blk_t r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = inv ? sbox_inv(v[4*n +: 4]) : sbox_fwd(v[4*n +: 4]);
    end
    return r;
  endfunction

  // 4x4 bit transpose, bit 4i+k goes to bit 4k+i
  function automatic blk_t transpose_blk(input blk_t v);
    blk_t r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        r[4*k + i] = v[4*i + k];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/spn_round.sv =====
module spn_round (
  input  logic              clk,
  input  logic              rst_n,
  input  spn_pkg::spn_ctl_t up_ctl,
  input  spn_pkg::blk_t     up_blk,
  output logic              up_rdy,
  input  spn_pkg::blk_t     rk_enc,
  input  spn_pkg::blk_t     rk_dec,
  input  spn_pkg::blk_t     wk_pre,
  input  spn_pkg::blk_t     wk_post,
  output spn_pkg::spn_ctl_t dn_ctl,
  output spn_pkg::blk_t     dn_blk,
  input  logic              dn_rdy
);

  spn_pkg::spn_ctl_t ctl_r, ctl_nxt;
  spn_pkg::blk_t     blk_r, blk_nxt;
  spn_pkg::blk_t     enc_res, dec_res;
  logic              adv;

  // stage advances when empty or when downstream takes its item
  assign up_rdy = !ctl_r.valid || dn_rdy;
  assign adv    = up_rdy;

  // one round in each direction
  always_comb begin
    enc_res = spn_pkg::transpose_blk(spn_pkg::sub_blk(up_blk ^ rk_enc, 1'b0)) ^ wk_post;
    dec_res = spn_pkg::sub_blk(spn_pkg::transpose_blk(up_blk ^ wk_pre), 1'b1) ^ rk_dec;
  end

  always_comb begin
    ctl_nxt = adv ? up_ctl : ctl_r;
    blk_nxt = blk_r;
    if (adv && up_ctl.valid) begin
      blk_nxt = (up_ctl.op == spn_pkg::OP_DEC) ? dec_res : enc_res;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, op: spn_pkg::OP_ENC};
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // data register
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign dn_ctl = ctl_r;
  assign dn_blk = blk_r;

endmodule

// ===== hdl/spn_block_cipher_16bit.sv =====
// 16-bit substitution-permutation block cipher, pipelined one round per stage
//
// in_*  : items with in_tuser = operation (0 encrypt, 1 decrypt) and
//         in_tdata = 16-bit block; accepted when in_tvalid and in_tready
// out_* : one 16-bit result block per item, in arrival order
// cfg_* : register port, subkey_0..subkey_6 at byte addresses 0x00..0x18,
//         low 16 bits of pwdata kept, writes beyond subkey_6 dropped
//
// an accepted item loads into the input register at the accepting edge, then passes
// one register stage per round (rounds capped at 6) before out_tvalid rises;
// the whitening XOR rides in the first stage for decrypt and the last for encrypt
// throughput is one item per cycle while out_tready stays high
// a stall on out_tready holds the full stages in an unbroken run from the output; empty stages still fill,
// so in_tready only drops once the pipe behind the stalled result is full
// reset clears all stage valid bits and the subkeys to zero
// subkeys are read live, so they are to be changed only while the pipe is empty; the block does not enforce it
`include "assert_macros.svh"

module spn_block_cipher_16bit #(
  parameter int unsigned NUM_ROUNDS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] block_in
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] block_out
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned Rounds = (NUM_ROUNDS > spn_pkg::MaxRnd) ? spn_pkg::MaxRnd :
                                   NUM_ROUNDS;
  localparam int unsigned KeyIdx = spn_pkg::KeyCnt - 1;

  // subkey registers
  spn_pkg::blk_t     key_r [spn_pkg::KeyCnt];
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spn_pkg::KeyCnt; i++) begin
        key_r[i] <= '0;
      end
    end else if (wr_en && (reg_idx < 3'(spn_pkg::KeyCnt))) begin
      key_r[reg_idx] <= cfg_pwdata[15:0];
    end
  end

  // register read back
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx < 3'(spn_pkg::KeyCnt)) begin
      cfg_prdata = {16'h0000, key_r[reg_idx]};
    end
  end

  // stage links: index 0 is the input register, index Rounds the output
  spn_pkg::spn_ctl_t st_ctl [Rounds+1];
  spn_pkg::blk_t     st_blk [Rounds+1];
  logic              st_rdy [Rounds+1];

  spn_pkg::spn_ctl_t in_ctl_r, in_ctl_nxt;
  spn_pkg::blk_t     in_blk_r, in_blk_nxt;

  // input register
  assign in_tready = !in_ctl_r.valid || st_rdy[0];

  always_comb begin
    in_ctl_nxt = in_ctl_r;
    in_blk_nxt = in_blk_r;
    if (in_tready) begin
      in_ctl_nxt.valid = in_tvalid;
      in_ctl_nxt.op    = spn_pkg::op_t'(in_tuser);
      in_blk_nxt       = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '{valid: 1'b0, op: spn_pkg::OP_ENC};
    end else begin
      in_ctl_r <= in_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_blk_r <= in_blk_nxt;
  end

  assign st_ctl[0] = in_ctl_r;
  assign st_blk[0] = in_blk_r;

  // round stages
  for (genvar j = 0; j < Rounds; j++) begin : g_rnd
    spn_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_ctl  (st_ctl[j]),
      .up_blk  (st_blk[j]),
      .up_rdy  (st_rdy[j]),
      .rk_enc  (key_r[j]),
      .rk_dec  (key_r[Rounds-1-j]),
      .wk_pre  ((j == 0) ? key_r[KeyIdx] : '0),
      .wk_post ((j == Rounds-1) ? key_r[KeyIdx] : '0),
      .dn_ctl  (st_ctl[j+1]),
      .dn_blk  (st_blk[j+1]),
      .dn_rdy  (st_rdy[j+1])
    );
  end

  // output side
  assign st_rdy[Rounds] = out_tready;
  assign out_tvalid     = st_ctl[Rounds].valid;
  assign out_tdata      = st_blk[Rounds];

  // an empty output stage lets the whole pipe move
  `SPN_ASSERT(a_empty_out_ready, !out_tvalid |-> in_tready, "pipe blocked with output empty")
  // a ready receiver keeps the pipe flowing end to end
  `SPN_ASSERT(a_flow_ready, out_tready |-> in_tready, "pipe blocked while receiver ready")
  // an accepted item lands in the input register
  `SPN_ASSERT(a_accept_lands, in_tvalid && in_tready |=> in_ctl_r.valid,
              "accepted item lost at input register")

endmodule

// ===== bench/spn_checker.sv =====
`timescale 1ns / 1ps

// watches the block's channels, predicts each result and compares it
module spn_checker #(
  parameter int unsigned ROUNDS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] block_in
  input  logic        in_tuser,   // [0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] block_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);

  // s-box tables, entry n in bits [4n+3:4n]
  localparam logic [63:0] SBOX_ENC = 64'hD192_730C_4ABE_856F;
  localparam logic [63:0] SBOX_DEC = 64'h04F8_56D3_B127_ACE9;
  localparam int unsigned USED_ROUNDS = (ROUNDS > spn_pkg::MaxRnd) ? spn_pkg::MaxRnd : ROUNDS;

  spn_pkg::blk_t subkeys [spn_pkg::KeyCnt];
  spn_pkg::blk_t expected_blocks [$];

  function automatic spn_pkg::blk_t substitute(input spn_pkg::blk_t v, input logic [63:0] box);
    spn_pkg::blk_t r;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = box[4*v[4*n +: 4] +: 4];
    end
    return r;
  endfunction

  // bit 4i+k moves to bit 4k+i
  function automatic spn_pkg::blk_t transpose(input spn_pkg::blk_t v);
    spn_pkg::blk_t r;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        r[4*k + i] = v[4*i + k];
      end
    end
    return r;
  endfunction

  function automatic spn_pkg::blk_t cipher_block(input spn_pkg::op_t op, input spn_pkg::blk_t b);
    if (op == spn_pkg::OP_ENC) begin
      for (int r = 0; r < USED_ROUNDS; r++) begin
        b = transpose(substitute(b ^ subkeys[r], SBOX_ENC));
      end
      b = b ^ subkeys[spn_pkg::KeyCnt-1];
    end else begin
      b = b ^ subkeys[spn_pkg::KeyCnt-1];
      for (int r = USED_ROUNDS; r > 0; r--) begin
        b = substitute(transpose(b), SBOX_DEC) ^ subkeys[r-1];
      end
    end
    return b;
  endfunction

  // first ten get printed, the rest are only counted
  task automatic note_mismatch(input string msg);
    if (errors < 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    spn_pkg::blk_t want;
    if (!rst_n) begin
      foreach (subkeys[i]) subkeys[i] = '0;
      expected_blocks.delete();
    end else begin
      // register port: track writes, check reads of the subkeys
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[4:2] < spn_pkg::KeyCnt) subkeys[cfg_paddr[4:2]] = cfg_pwdata[15:0];
        end else if (cfg_paddr[4:2] < spn_pkg::KeyCnt &&
                     cfg_prdata[15:0] !== subkeys[cfg_paddr[4:2]]) begin
          note_mismatch($sformatf("subkey %0d read expected %h got %h", cfg_paddr[4:2],
                                  subkeys[cfg_paddr[4:2]], cfg_prdata[15:0]));
        end
      end
      // accepted input item
      if (in_tvalid && in_tready) begin
        expected_blocks.push_back(cipher_block(spn_pkg::op_t'(in_tuser), in_tdata));
      end
      // accepted result item
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          note_mismatch($sformatf("result %h with nothing expected", out_tdata));
        end else begin
          want = expected_blocks.pop_front();
          if (out_tdata !== want) begin
            note_mismatch($sformatf("block_out expected %h got %h", want, out_tdata));
          end
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ROUNDS = 6;
  localparam int unsigned SPARE_IDX = spn_pkg::KeyCnt;  // first address past the subkeys
  localparam int LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors;
  int pending;
  int cycles = 0;
  int send_mode = 0;
  int recv_mode = 0;
  bit long_hold = 1'b0;

  spn_block_cipher_16bit #(.NUM_ROUNDS(ROUNDS)) dut (.*);

  spn_checker #(.ROUNDS(ROUNDS)) cipher_check (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // wait cycles before an item: none, any, or mostly none
  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  task automatic send_block(input spn_pkg::op_t op, input spn_pkg::blk_t blk, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= blk;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and let every expected result drain
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic reg_access(input bit wr, input int idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // write all subkeys with junk in the upper half, poke the spare slot, read back
  task automatic load_subkeys(input int pattern);
    logic [15:0] k;
    for (int i = 0; i < spn_pkg::KeyCnt; i++) begin
      case (pattern)
        0: k = 16'h0000;
        1: k = 16'hFFFF;
        2: k = (i % 2) ? 16'h5555 : 16'hAAAA;
        default: k = 16'($urandom);
      endcase
      reg_access(1'b1, i, {16'($urandom), k});
    end
    reg_access(1'b1, SPARE_IDX, $urandom);
    for (int i = 0; i <= SPARE_IDX; i++) begin
      reg_access(1'b0, i, '0);
    end
  endtask

  // result side
  initial begin
    int stall;
    int served;
    served = 0;
    wait (rst_n);
    forever begin
      stall = long_hold ? LONG_HOLD : draw_wait(recv_mode);
      long_hold = 1'b0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      served++;
      if (served % 64 == 0) recv_mode = $urandom_range(0, 2);
    end
  end

  // stimulus
  initial begin
    spn_pkg::blk_t corners [8];
    spn_pkg::blk_t blk;
    int sent;
    corners = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                16'h0001, 16'h8000, 16'h0F0F, 16'hF0F0};
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-zero subkeys after reset
    send_block(spn_pkg::OP_ENC, 16'h0000, 1);
    send_block(spn_pkg::OP_DEC, 16'h0000, 0);
    send_block(spn_pkg::OP_ENC, 16'hFFFF, 3);
    send_block(spn_pkg::OP_DEC, 16'hFFFF, 0);
    drain();

    // directed: corner blocks both ways under random subkeys
    load_subkeys(3);
    foreach (corners[i]) begin
      send_block(spn_pkg::OP_ENC, corners[i], 0);
      send_block(spn_pkg::OP_DEC, corners[i], (i % 3 == 2) ? 2 : 0);
    end
    drain();

    // random phases, each under a fresh subkey setting
    for (int phase = 0; phase < PHASES; phase++) begin
      load_subkeys(phase < 3 ? phase : 3);
      if (phase == 2) long_hold = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sent % 64 == 0) send_mode = $urandom_range(0, 2);
        // sender pauses until the pipe has emptied
        if (phase == 4 && n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(0, 9) == 0) blk = corners[$urandom_range(0, 7)];
        else blk = 16'($urandom);
        send_block(spn_pkg::op_t'($urandom_range(0, 1)), blk,
                   (phase == 2 && n < 40) ? 0 : draw_wait(send_mode));
        sent++;
      end
      drain();
    end

    // after the last drain, wait on for stray results
    repeat (ROUNDS + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
